// ===== sv/indexed_priority_task_queue_assert.svh =====
// assertion macros shared by the task queue rtl
`ifndef INDEXED_PRIORITY_TASK_QUEUE_ASSERT_SVH
`define INDEXED_PRIORITY_TASK_QUEUE_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define IPQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define IPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/ipq_pkg.sv =====
// types, constants and codes of the indexed priority task queue
`default_nettype none

package ipq_pkg;

   localparam int MAX_TASKS = 64;
   localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int POS_W     = $clog2(MAX_TASKS + 1);
   localparam int KEY_W     = 16;
   localparam int OWNER_W   = 16;
   localparam int PRIO_W    = 31;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_EDIT   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_TOP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      op_type              operation;
      logic [OWNER_W-1:0]  owner_id;
      logic [KEY_W-1:0]    task_key;
      logic [PRIO_W-1:0]   task_priority;
   } req_type;

   typedef struct packed {
      logic [OWNER_W-1:0]  top_owner;
      status_type          status;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic [KEY_W-1:0]    task_key;
      logic [OWNER_W-1:0]  owner_id;
      logic [PRIO_W-1:0]   task_priority;
   } entry_type;

   // broadcast to every cell: shift ranges and insert slot
   typedef struct packed {
      logic                apply;
      logic [POS_W-1:0]    shl_lo;    // take right neighbor when shl_lo <= i < shl_end
      logic [POS_W-1:0]    shl_end;
      logic [POS_W-1:0]    shr_lo;    // take left neighbor when shr_lo < i <= shr_hi
      logic [POS_W-1:0]    shr_hi;
      logic                ins_en;
      logic [POS_W-1:0]    ins_pos;
      entry_type           ins_entry;
   } shift_ctrl_type;

   // result of the search pass over the chain
   typedef struct packed {
      logic                found;
      logic [IDX_W-1:0]    match_idx;
      logic [POS_W-1:0]    ins_pos;
      logic [OWNER_W-1:0]  owner_id;
   } scan_type;

endpackage

`default_nettype wire

// ===== sv/ipq_cell.sv =====
// one slot of the sorted task chain
`default_nettype none

module ipq_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ipq_pkg::IDX_W-1:0]     cell_index,
   input  ipq_pkg::req_type              probe,
   input  ipq_pkg::entry_type            left_in,
   input  ipq_pkg::entry_type            right_in,
   input  ipq_pkg::shift_ctrl_type       ctrl,
   output ipq_pkg::entry_type            entry_out,
   output logic                          match_out,
   output logic                          greater_out
);

   import ipq_pkg::*;

   `include "indexed_priority_task_queue_assert.svh"

   entry_type           entry_ff;
   entry_type           entry_in;
   logic [POS_W-1:0]    pos;
   logic                take_right;
   logic                take_left;
   logic                take_new;

   assign pos = POS_W'(cell_index);

   // compare the probe against the held entry
   assign match_out   = entry_ff.valid && (entry_ff.task_key == probe.task_key);
   assign greater_out = !entry_ff.valid
                        || ({probe.task_priority, probe.task_key}
                            > {entry_ff.task_priority, entry_ff.task_key});

   // decode the broadcast ranges against this slot
   assign take_right = (pos >= ctrl.shl_lo) && (pos < ctrl.shl_end);
   assign take_left  = (pos > ctrl.shr_lo) && (pos <= ctrl.shr_hi);
   assign take_new   = ctrl.ins_en && (pos == ctrl.ins_pos);

   // next entry
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.apply) begin
         priority if (take_new) begin
            entry_in = ctrl.ins_entry;
         end else if (take_right) begin
            entry_in = right_in;
         end else if (take_left) begin
            entry_in = left_in;
         end
      end
   end

   // slot register, only the valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry_out = entry_ff;

   // chain stays packed toward slot zero and sorted high to low
   `IPQ_ASSERT_SAME(a_cell_packed, entry_ff.valid && (cell_index != '0), left_in.valid,
      "valid slot behind an empty one")
   `IPQ_ASSERT_SAME(a_cell_sorted, entry_ff.valid && (cell_index != '0),
      {left_in.task_priority, left_in.task_key} > {entry_ff.task_priority, entry_ff.task_key},
      "chain out of order")

endmodule

`default_nettype wire

// ===== sv/ipq_scan.sv =====
// encodes match and insert position from the cell flags and registers them
`default_nettype none

module ipq_scan (
   input  logic                                               clock,
   input  logic                                               capture,
   input  logic [ipq_pkg::MAX_TASKS-1:0]                      match_vec,
   input  logic [ipq_pkg::MAX_TASKS-1:0]                      greater_vec,
   input  logic [ipq_pkg::MAX_TASKS-1:0][ipq_pkg::OWNER_W-1:0] owner_vec,
   output ipq_pkg::scan_type                                  scan_out
);

   import ipq_pkg::*;

   scan_type                scan_ff;
   scan_type                scan_in;
   logic [MAX_TASKS-1:0]    edge_vec;
   logic [IDX_W-1:0]        edge_idx;
   logic [IDX_W-1:0]        match_idx;
   logic [OWNER_W-1:0]      owner_sel;

   // first greater slot: the one-hot 0 to 1 step of a monotone flag row
   always_comb begin
      for (int i = 0; i < MAX_TASKS; i++) begin
         if (i == 0) begin
            edge_vec[i] = greater_vec[i];
         end else begin
            edge_vec[i] = greater_vec[i] && !greater_vec[i-1];
         end
      end
   end

   // or-tree encoders over one-hot rows
   always_comb begin
      edge_idx  = '0;
      match_idx = '0;
      owner_sel = '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
         edge_idx  = edge_idx  | (edge_vec[i]  ? IDX_W'(i) : '0);
         match_idx = match_idx | (match_vec[i] ? IDX_W'(i) : '0);
         owner_sel = owner_sel | (match_vec[i] ? owner_vec[i] : '0);
      end
   end

   always_comb begin
      scan_in.found     = |match_vec;
      scan_in.match_idx = match_idx;
      scan_in.ins_pos   = (|greater_vec) ? POS_W'(edge_idx) : POS_W'(MAX_TASKS);
      scan_in.owner_id  = owner_sel;
   end

   // search result register
   always_ff @(posedge clock) begin
      if (capture) begin
         scan_ff <= scan_in;
      end
   end

   assign scan_out = scan_ff;

endmodule

`default_nettype wire

// ===== sv/indexed_priority_task_queue.sv =====
// indexed max-priority task queue: a sorted chain of task slots
//
// Commands enter on req_payload and are taken on a clock edge where start is
// high and busy is low. Each command is one of add, edit priority, remove by
// task key, or execute top; execute top removes the task of highest priority
// (larger task key wins a tie) and returns its owner.
// Every command gives exactly one beat on rsp_payload, marked by rsp_valid for
// one cycle; the receiver cannot stall it and must take it.
// Sequence: the accept cycle searches all slots in parallel (key match and
// insert position); busy is then high for one cycle while the chain shifts and
// writes. The result beat is registered at the edge that ends that cycle and
// is taken on the following edge; a new command can be taken on that same edge.
// The chain is kept sorted with the top task in slot zero; each slot only
// exchanges data with its two neighbors and the broadcast insert entry.
// Reset (synchronous, active high) empties the store by clearing the slot
// valid bits; no result is pending after reset.
`default_nettype none

module indexed_priority_task_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ipq_pkg::req_type  req_payload,
   output logic              rsp_valid,
   output ipq_pkg::rsp_type  rsp_payload
);

   import ipq_pkg::*;

   `include "indexed_priority_task_queue_assert.svh"

   typedef enum logic [1:0] {
      S_IDLE   = 2'b01,
      S_UPDATE = 2'b10
   } state_type;

   state_type                          state_ff;
   state_type                          state_in;
   req_type                            req_ff;
   logic                               accept;
   logic                               rsp_valid_ff;
   rsp_type                            rsp_ff;
   rsp_type                            rsp_in;
   shift_ctrl_type                     ctrl;
   scan_type                           scan;
   entry_type                          entries [MAX_TASKS];
   logic [MAX_TASKS-1:0]               match_vec;
   logic [MAX_TASKS-1:0]               greater_vec;
   logic [MAX_TASKS-1:0][OWNER_W-1:0]  owner_vec;
   logic [POS_W-1:0]                   match_pos;
   logic                               store_full;
   logic                               store_empty;

   assign busy   = (state_ff == S_UPDATE);
   assign accept = start && !busy;

   // slot chain
   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      entry_type left_nb;
      entry_type right_nb;
      if (i == 0) begin : g_first
         assign left_nb = '0;
      end else begin : g_mid_l
         assign left_nb = entries[i-1];
      end
      if (i == MAX_TASKS - 1) begin : g_last
         assign right_nb = '0;
      end else begin : g_mid_r
         assign right_nb = entries[i+1];
      end
      ipq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_index  (IDX_W'(i)),
         .probe       (req_payload),
         .left_in     (left_nb),
         .right_in    (right_nb),
         .ctrl        (ctrl),
         .entry_out   (entries[i]),
         .match_out   (match_vec[i]),
         .greater_out (greater_vec[i])
      );
      assign owner_vec[i] = entries[i].owner_id;
   end

   // search result capture
   ipq_scan u_scan (
      .clock       (clock),
      .capture     (accept),
      .match_vec   (match_vec),
      .greater_vec (greater_vec),
      .owner_vec   (owner_vec),
      .scan_out    (scan)
   );

   // command register
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_payload;
      end
   end

   assign store_full  = entries[MAX_TASKS-1].valid;
   assign store_empty = !entries[0].valid;
   // with no match the last slot is dropped, it is empty whenever an add goes ahead
   assign match_pos   = scan.found ? POS_W'(scan.match_idx) : POS_W'(MAX_TASKS - 1);

   // shift control and status for the update cycle
   always_comb begin
      ctrl                     = '0;
      ctrl.apply               = (state_ff == S_UPDATE);
      ctrl.ins_entry.valid     = 1'b1;
      ctrl.ins_entry.task_key  = req_ff.task_key;
      ctrl.ins_entry.owner_id  = (req_ff.operation == OP_EDIT) ? scan.owner_id
                                                              : req_ff.owner_id;
      ctrl.ins_entry.task_priority = req_ff.task_priority;
      rsp_in.top_owner         = '0;
      rsp_in.status            = STAT_OK;
      unique case (req_ff.operation)
         OP_ADD, OP_EDIT: begin
            if (req_ff.operation == OP_EDIT && !scan.found) begin
               rsp_in.status = STAT_NOT_FOUND;
            end else if (req_ff.operation == OP_ADD && !scan.found && store_full) begin
               rsp_in.status = STAT_FULL;
            end else if (match_pos < scan.ins_pos) begin
               // old slot lies ahead: close it up, new entry lands just before
               ctrl.ins_en  = 1'b1;
               ctrl.shl_lo  = match_pos;
               ctrl.shl_end = scan.ins_pos - POS_W'(1);
               ctrl.ins_pos = scan.ins_pos - POS_W'(1);
            end else begin
               // open a gap at the insert slot, swallowing the old slot
               ctrl.ins_en  = 1'b1;
               ctrl.shr_lo  = scan.ins_pos;
               ctrl.shr_hi  = match_pos;
               ctrl.ins_pos = scan.ins_pos;
            end
         end
         OP_REMOVE: begin
            if (!scan.found) begin
               rsp_in.status = STAT_NOT_FOUND;
            end else begin
               ctrl.shl_lo  = match_pos;
               ctrl.shl_end = POS_W'(MAX_TASKS);
            end
         end
         OP_TOP: begin
            if (store_empty) begin
               rsp_in.status = STAT_EMPTY;
            end else begin
               rsp_in.top_owner = entries[0].owner_id;
               ctrl.shl_lo      = '0;
               ctrl.shl_end     = POS_W'(MAX_TASKS);
            end
         end
         default: begin
            rsp_in.status = STAT_OK;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == S_UPDATE);
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (state_ff == S_UPDATE) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // every accepted command yields its beat after the update cycle
   `IPQ_ASSERT_NEXT(a_top_latency, accept, ##1 rsp_valid,
      "missing result beat after accept")
   // update lasts exactly one cycle
   `IPQ_ASSERT_NEXT(a_top_update_len, busy, !busy,
      "update state held too long")
   // an owner is only reported by a successful execute top
   `IPQ_ASSERT_SAME(a_top_owner_zero, rsp_valid && (rsp_payload.status != STAT_OK),
      rsp_payload.top_owner == '0, "owner reported on a failed command")

endmodule

`default_nettype wire

// ===== tb/sv/task_queue_checker.sv =====
// checker for the task queue: watches both channels, predicts each status beat and compares
module task_queue_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  ipq_pkg::req_type  req_payload,
   input  logic              rsp_valid,
   input  ipq_pkg::rsp_type  rsp_payload,
   output int unsigned       mismatches,
   output int unsigned       outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import ipq_pkg::*;

   // shadow copy of the task store
   logic               slot_live  [MAX_TASKS];
   logic [KEY_W-1:0]   slot_key   [MAX_TASKS];
   logic [OWNER_W-1:0] slot_owner [MAX_TASKS];
   logic [PRIO_W-1:0]  slot_prio  [MAX_TASKS];

   // status beats owed by the block, oldest first
   rsp_type            owed_beats [$];

   function automatic int slot_of_key(input logic [KEY_W-1:0] key);
      for (int i = 0; i < MAX_TASKS; i++) begin
         if (slot_live[i] && slot_key[i] == key) return i;
      end
      return -1;
   endfunction

   function automatic int lowest_free_slot();
      for (int i = 0; i < MAX_TASKS; i++) begin
         if (!slot_live[i]) return i;
      end
      return -1;
   endfunction

   // highest priority wins, larger key breaks a tie
   function automatic int top_task_slot();
      int best;
      best = -1;
      for (int i = 0; i < MAX_TASKS; i++) begin
         if (slot_live[i]) begin
            if (best < 0 || slot_prio[i] > slot_prio[best] ||
                (slot_prio[i] == slot_prio[best] && slot_key[i] > slot_key[best]))
               best = i;
         end
      end
      return best;
   endfunction

   // apply one command to the shadow store and return its status beat
   function automatic rsp_type apply_command(input req_type cmd);
      rsp_type outcome;
      int      slot;
      outcome.top_owner = '0;
      outcome.status    = STAT_OK;
      case (cmd.operation)
         OP_ADD: begin
            slot = slot_of_key(cmd.task_key);
            if (slot < 0) slot = lowest_free_slot();
            if (slot < 0) begin
               outcome.status = STAT_FULL;
            end else begin
               slot_live[slot]  = 1'b1;
               slot_key[slot]   = cmd.task_key;
               slot_owner[slot] = cmd.owner_id;
               slot_prio[slot]  = cmd.task_priority;
            end
         end
         OP_EDIT: begin
            slot = slot_of_key(cmd.task_key);
            if (slot < 0) outcome.status = STAT_NOT_FOUND;
            else slot_prio[slot] = cmd.task_priority;
         end
         OP_REMOVE: begin
            slot = slot_of_key(cmd.task_key);
            if (slot < 0) outcome.status = STAT_NOT_FOUND;
            else slot_live[slot] = 1'b0;
         end
         default: begin
            slot = top_task_slot();
            if (slot < 0) begin
               outcome.status = STAT_EMPTY;
            end else begin
               outcome.top_owner = slot_owner[slot];
               slot_live[slot]   = 1'b0;
            end
         end
      endcase
      return outcome;
   endfunction

   // compare result beats first, then record the command taken on this edge
   always @(posedge clock) begin
      rsp_type owed;
      if (reset) begin
         for (int i = 0; i < MAX_TASKS; i++) slot_live[i] = 1'b0;
         owed_beats.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (owed_beats.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected status beat owner %h status %0d", $time,
                        rsp_payload.top_owner, rsp_payload.status);
            end else begin
               owed = owed_beats.pop_front();
               if (rsp_payload.top_owner !== owed.top_owner) begin
                  mismatches++;
                  $display("%0t: top_owner expected %h actual %h", $time,
                           owed.top_owner, rsp_payload.top_owner);
               end
               if (rsp_payload.status !== owed.status) begin
                  mismatches++;
                  $display("%0t: status expected %s actual %0d", $time,
                           owed.status.name(), rsp_payload.status);
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            owed_beats.push_back(apply_command(req_payload));
      end
      outstanding = owed_beats.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
// top of the task queue testbench: clock, reset, command stimulus and verdict
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ipq_pkg::*;

   typedef enum {PHASE_FILL, PHASE_MIX, PHASE_DRAIN} phase_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_payload;
   logic        rsp_valid;
   rsp_type     rsp_payload;
   int unsigned mismatches;
   int unsigned outstanding;

   indexed_priority_task_queue DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   task_queue_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic req_type command(input op_type op, input logic [OWNER_W-1:0] owner,
                                       input logic [KEY_W-1:0] key,
                                       input logic [PRIO_W-1:0] prio);
      req_type cmd;
      cmd.operation     = op;
      cmd.owner_id      = owner;
      cmd.task_key      = key;
      cmd.task_priority = prio;
      return cmd;
   endfunction

   // idle cycles carry junk on the payload, then the beat is held until taken
   task automatic issue(input req_type beat, input int unsigned idle);
      logic [95:0] junk;
      repeat (idle) begin
         @(negedge clock);
         junk        = {$urandom, $urandom, $urandom};
         start       = 1'b0;
         req_payload = junk[$bits(req_type)-1:0];
      end
      @(negedge clock);
      start       = 1'b1;
      req_payload = beat;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // mostly back to back, some short gaps, a few long ones
   function automatic int unsigned pick_gap(input bit calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // keys mostly from a narrow window so edits, removes and re-adds hit live tasks
   function automatic logic [KEY_W-1:0] pick_key(input int unsigned base);
      if ($urandom_range(0, 99) < 94) return KEY_W'(base + $urandom_range(0, 95));
      return KEY_W'($urandom);
   endfunction

   // small priorities give ties, plus full range and both extremes
   function automatic logic [PRIO_W-1:0] pick_prio();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return PRIO_W'($urandom_range(0, 7));
      if (r < 80) return PRIO_W'($urandom);
      if (r < 90) return '0;
      return '1;
   endfunction

   function automatic op_type pick_op(input phase_type kind);
      int unsigned r;
      int unsigned add_pct;
      int unsigned top_pct;
      r = $urandom_range(0, 99);
      case (kind)
         PHASE_FILL: begin
            add_pct = 70;
            top_pct = 10;
         end
         PHASE_MIX: begin
            add_pct = 35;
            top_pct = 25;
         end
         default: begin
            add_pct = 15;
            top_pct = 55;
         end
      endcase
      if (r < add_pct) return OP_ADD;
      if (r >= 100 - top_pct) return OP_TOP;
      if (r < add_pct + (100 - add_pct - top_pct) / 2) return OP_EDIT;
      return OP_REMOVE;
   endfunction

   initial begin
      int unsigned sent;
      int unsigned run_len;
      int unsigned key_base;
      int unsigned waited;
      int unsigned phase_no;
      int unsigned r;
      bit          calm;
      phase_type   kind;

      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty store, absent keys, extremes, ties and replacement
      issue(command(OP_TOP,    16'h0000, 16'h0000, 31'h0), 0);
      issue(command(OP_EDIT,   16'h0000, 16'h0005, 31'h1), 0);
      issue(command(OP_REMOVE, 16'h0000, 16'h0000, 31'h0), 1);
      issue(command(OP_ADD,    16'h0000, 16'h0000, 31'h0), 0);
      issue(command(OP_ADD,    16'hffff, 16'hffff, 31'h7fffffff), 0);
      issue(command(OP_ADD,    16'h1234, 16'h0064, 31'h7fffffff), 2);
      issue(command(OP_ADD,    16'h4321, 16'h0064, 31'h5), 0);
      issue(command(OP_EDIT,   16'h0000, 16'h0000, 31'h7fffffff), 0);
      issue(command(OP_ADD,    16'haaaa, 16'h0007, 31'h5), 0);
      issue(command(OP_TOP,    16'h0000, 16'h0000, 31'h0), 0);
      issue(command(OP_TOP,    16'h0000, 16'h0000, 31'h0), 1);
      issue(command(OP_TOP,    16'h0000, 16'h0000, 31'h0), 0);
      issue(command(OP_REMOVE, 16'h0000, 16'h0007, 31'h0), 0);
      issue(command(OP_REMOVE, 16'h0000, 16'h0007, 31'h0), 3);
      issue(command(OP_TOP,    16'h0000, 16'h0000, 31'h0), 0);
      issue(command(OP_ADD,    16'h5555, 16'h5555, 31'h2aaaaaaa), 0);
      issue(command(OP_ADD,    16'haaaa, 16'haaaa, 31'h55555555), 0);
      issue(command(OP_EDIT,   16'h0000, 16'haaaa, 31'h0), 0);
      issue(command(OP_TOP,    16'h0000, 16'h0000, 31'h0), 0);
      issue(command(OP_TOP,    16'h0000, 16'h0000, 31'h0), 0);
      issue(command(OP_TOP,    16'h0000, 16'h0000, 31'h0), 0);

      // random phases cycling through fill, mixed traffic and drain
      sent     = 0;
      phase_no = 0;
      while (sent < 1750) begin
         case (phase_no % 3)
            0:       kind = PHASE_FILL;
            1:       kind = PHASE_MIX;
            default: kind = PHASE_DRAIN;
         endcase
         run_len = (kind == PHASE_FILL) ? $urandom_range(90, 160) : $urandom_range(40, 120);
         r = $urandom_range(0, 9);
         if (r == 0) key_base = 0;
         else if (r == 1) key_base = 65536 - 96;
         else key_base = $urandom_range(0, 65536 - 96);
         calm = ($urandom_range(0, 3) == 0);
         for (int unsigned n = 0; n < run_len && sent < 1750; n++) begin
            issue(command(pick_op(kind), OWNER_W'($urandom), pick_key(key_base), pick_prio()),
                  pick_gap(calm));
            sent++;
         end
         phase_no++;
      end
      @(negedge clock);
      start = 1'b0;

      // let the last status beats come out
      waited = 0;
      while (outstanding != 0 && waited < 200) begin
         @(negedge clock);
         waited++;
      end
      repeat (8) @(negedge clock);

      if (mismatches == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         if (outstanding != 0)
            $display("%0t: %0d status beats never arrived", $time, outstanding);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
